[rtl/cobsdec_pkg.sv]
// Shared types and functions for the COBS frame decoder with CRC-16 check.
// Holds the status codes, register indexes and the CRC-16-CCITT byte update.
// No dependencies.
package cobsdec_pkg;

  typedef enum logic [2:0] {
    ST_CONSUMED   = 3'd0,
    ST_READY      = 3'd1,
    ST_CRC_ERR    = 3'd2,
    ST_DECODE_ERR = 3'd3,
    ST_OVERFLOW   = 3'd4
  } status_t;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_READ = 1'b1
  } op_t;

  localparam logic [7:0] CFG_MAX_LENGTH = 8'd0;
  localparam logic [7:0] CFG_CRC_INIT   = 8'd1;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // One byte of CRC-16-CCITT, MSB first, no reflection.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/cobsdec_ram.sv]
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Used for the decoded packet store. No dependencies.
module cobsdec_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/cobs_frame_decoder_crc16_top.sv]
// Top level of the COBS frame decoder with running CRC-16-CCITT check.
// Depends on cobsdec_pkg and cobsdec_ram.
//
// The slave stream carries requests: tuser selects feeding one encoded byte or
// reading one decoded byte. Every request yields exactly one result on the
// master stream, with the status code in tuser and the data byte and packet
// length in tdata. Encoded bytes are decoded into a packet store; a zero byte
// ends the frame and checks the CRC over all but the last two stored bytes
// against those two bytes, big-endian. Reads return a stored byte of the last
// finished frame together with its length.
// The configuration channel writes max_length (index 0) and crc_init
// (index 1) and is always ready; the user must write it only while the block
// is idle, which the block itself does not enforce. An accepted request passes
// the input register, then the decode step and the store access into the result
// register, whose read data comes from the registered RAM port.
// Throughput is one request per cycle. When the receiver stalls, the result
// holds, one more request may wait in the input register, and then tready
// drops. Reset clears the decoder state and loads the register defaults.
module cobs_frame_decoder_crc16_top
  import cobsdec_pkg::*;
#(
  parameter int STORE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte [7:0], read_index [15:8]
  input  logic        s_axis_tuser,   // op [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // data_out [7:0], packet_length [16:8], zero [23:17]
  output logic [2:0]  m_axis_tuser,   // status [2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [8:0]  max_length;
  logic [15:0] crc_init;

  logic        s1_valid;
  logic        s1_op;
  logic [7:0]  s1_byte;
  logic [7:0]  s1_idx;
  logic        s1_adv;

  logic        m_valid;
  status_t     m_status;
  logic [8:0]  m_len;
  logic        m_hit;
  logic [7:0]  ram_q;

  logic [8:0]  write_count;
  logic [7:0]  block_remaining;
  logic        in_block;
  logic        code_is_full;
  logic        zero_pending;
  logic        frame_done;
  logic [15:0] crc_running;
  logic [7:0]  hold0;
  logic [7:0]  hold1;

  logic [8:0]  write_count_next;
  logic [7:0]  block_remaining_next;
  logic        in_block_next;
  logic        code_is_full_next;
  logic        zero_pending_next;
  logic        frame_done_next;
  logic [15:0] crc_running_next;
  logic [7:0]  hold0_next;
  logic [7:0]  hold1_next;
  status_t     status_next;
  logic [8:0]  len_next;
  logic        hit_next;
  logic        store_we;
  logic [7:0]  store_wdata;
  logic [8:0]  limit;
  logic [31:0] waddr_ext;
  logic [31:0] raddr_ext;

  assign cfg_ready     = 1'b1;
  assign s1_adv        = s1_valid && (!m_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tuser  = m_status;
  assign m_axis_tdata  = {7'd0, m_len, (m_hit ? ram_q : 8'd0)};

  assign limit = (32'(max_length) > STORE_DEPTH) ? 9'(STORE_DEPTH) : max_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= 9'd256;
      crc_init   <= 16'hFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_LENGTH: max_length <= cfg_data[8:0];
        CFG_CRC_INIT:   crc_init   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_op   <= s_axis_tuser;
      s1_byte <= s_axis_tdata[7:0];
      s1_idx  <= s_axis_tdata[15:8];
    end
  end

  always_comb begin
    logic [8:0]  wc;
    logic [7:0]  brem;
    logic        inb;
    logic        full;
    logic        zp;
    logic [15:0] crc;
    logic [7:0]  h0;
    logic [7:0]  h1;
    logic        store_req;
    logic        take;

    wc   = write_count;
    brem = block_remaining;
    inb  = in_block;
    full = code_is_full;
    zp   = zero_pending;
    crc  = crc_running;
    h0   = hold0;
    h1   = hold1;
    store_we    = 1'b0;
    store_wdata = zero_pending ? 8'd0 : s1_byte;
    status_next = ST_CONSUMED;
    hit_next    = 1'b0;
    take        = 1'b0;
    store_req   = 1'b0;
    frame_done_next = frame_done;

    if (s1_op == OP_READ) begin
      hit_next = frame_done && ({1'b0, s1_idx} < write_count);
      len_next = frame_done ? write_count : 9'd0;
    end else begin
      if (frame_done) begin
        wc   = 9'd0;
        brem = 8'd0;
        inb  = 1'b0;
        full = 1'b0;
        zp   = 1'b0;
        crc  = crc_init;
        h0   = 8'd0;
        h1   = 8'd0;
        frame_done_next = 1'b0;
      end
      store_wdata = zp ? 8'd0 : s1_byte;
      if (s1_byte == 8'd0) begin
        if (inb) begin
          status_next = ST_DECODE_ERR;
        end else if (wc < 9'd2 || {h0, h1} != crc) begin
          status_next = ST_CRC_ERR;
        end else begin
          wc = wc - 9'd2;
          status_next = ST_READY;
        end
      end else begin
        store_req = zp || inb;
        take      = !inb || zp;
        if (store_req && wc >= limit) begin
          status_next = ST_OVERFLOW;
          take = 1'b0;
        end else if (store_req) begin
          store_we = 1'b1;
          if (wc >= 9'd2) begin
            crc = crc16_byte(crc, h0);
          end
          h0 = h1;
          h1 = store_wdata;
          wc = wc + 9'd1;
          if (zp) begin
            zp = 1'b0;
          end else begin
            if (brem != 8'd0) begin
              brem = brem - 8'd1;
            end
            if (brem == 8'd0) begin
              inb = 1'b0;
              if (!full) begin
                zp = 1'b1;
              end
            end
          end
        end
        if (take) begin
          if (s1_byte == 8'd1) begin
            inb  = 1'b0;
            zp   = 1'b1;
            brem = 8'd0;
            full = 1'b0;
          end else begin
            inb  = 1'b1;
            brem = s1_byte - 8'd1;
            full = (s1_byte == 8'hFF);
          end
        end
      end
      if (status_next != ST_CONSUMED) begin
        frame_done_next = 1'b1;
      end
      len_next = frame_done_next ? wc : 9'd0;
    end

    write_count_next     = wc;
    block_remaining_next = brem;
    in_block_next        = inb;
    code_is_full_next    = full;
    zero_pending_next    = zp;
    crc_running_next     = crc;
    hold0_next           = h0;
    hold1_next           = h1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count     <= 9'd0;
      block_remaining <= 8'd0;
      in_block        <= 1'b0;
      code_is_full    <= 1'b0;
      zero_pending    <= 1'b0;
      frame_done      <= 1'b0;
      crc_running     <= 16'hFFFF;
      hold0           <= 8'd0;
      hold1           <= 8'd0;
    end else if (s1_adv && s1_op == OP_FEED) begin
      write_count     <= write_count_next;
      block_remaining <= block_remaining_next;
      in_block        <= in_block_next;
      code_is_full    <= code_is_full_next;
      zero_pending    <= zero_pending_next;
      frame_done      <= frame_done_next;
      crc_running     <= crc_running_next;
      hold0           <= hold0_next;
      hold1           <= hold1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (s1_adv) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_status <= status_next;
      m_len    <= len_next;
      m_hit    <= hit_next;
    end
  end

  // Feeds write at the position before the decode step; reads use the index.
  assign waddr_ext = 32'(frame_done ? 9'd0 : write_count);
  assign raddr_ext = 32'(s1_idx);

  cobsdec_ram #(
    .WIDTH(8),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (s1_adv && s1_op == OP_FEED && store_we),
    .waddr(waddr_ext[AW-1:0]),
    .wdata(store_wdata),
    .re   (s1_adv && s1_op == OP_READ),
    .raddr(raddr_ext[AW-1:0]),
    .rdata(ram_q)
  );

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_axis_tready) |=> (m_valid && $stable(m_status) && $stable(m_len)))
    else $error("result register overwritten while stalled");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_op == OP_FEED && status_next != ST_CONSUMED) |=> frame_done)
    else $error("frame not closed after a terminating status");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(write_count) <= STORE_DEPTH))
    else $error("write count beyond store depth");

  a_ready_len: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_op == OP_FEED && status_next == ST_READY)
      |=> (write_count == $past(write_count) - 9'd2))
    else $error("packet ready without stripping the check bytes");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for cobs_frame_decoder_crc16_top: COBS frames with CRC-16 trailers,
// reads of the decoded packet, and random noise, checked against a cycle-free decoder model.
// Depends on cobsdec_pkg and the decoder RTL.
module tb_top;
  import cobsdec_pkg::*;

  localparam int DEPTH       = 256;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [7:0] byte_q[$];

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_out;
    logic [8:0] pkt_len;
  } result_t;

  typedef enum int {FRAME_GOOD, FRAME_BAD_CRC, FRAME_CUT} frame_kind_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index     = '0;
  logic [15:0] cfg_data      = '0;

  cobs_frame_decoder_crc16_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  req_t    pending_q[$];
  result_t expected_q[$];
  req_t    cur_req;
  result_t want;
  int      queued_items   = 0;
  int      accepted_total = 0;
  int      error_count    = 0;
  int      cycle_count    = 0;
  int      sender_idle_pct = 0;
  int      sink_idle_pct   = 0;
  int      hold_left       = 0;
  bit      hold_used       = 1'b0;

  // Decoder model state.
  logic [8:0]  cfg_max_len  = 9'd256;
  logic [15:0] cfg_crc_init = 16'hFFFF;
  logic [7:0]  store_mem[DEPTH];
  logic [8:0]  wr_count;
  logic [7:0]  blk_left;
  bit          in_blk, full_code, zero_due, done;
  logic [15:0] crc_acc;
  logic [7:0]  hold0, hold1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int k = 7; k >= 0; k--) begin
      r = (r[15] ^ b[k]) ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [8:0] length_cap();
    return (cfg_max_len > 9'(DEPTH)) ? 9'(DEPTH) : cfg_max_len;
  endfunction

  function automatic void clear_frame();
    wr_count  = '0;
    blk_left  = '0;
    in_blk    = 1'b0;
    full_code = 1'b0;
    zero_due  = 1'b0;
    done      = 1'b0;
    crc_acc   = cfg_crc_init;
    hold0     = '0;
    hold1     = '0;
  endfunction

  function automatic bit store_decoded(input logic [7:0] b);
    if (wr_count >= length_cap()) return 1'b0;
    store_mem[wr_count[7:0]] = b;
    if (wr_count >= 9'd2) crc_acc = crc16_next(crc_acc, hold0);
    hold0    = hold1;
    hold1    = b;
    wr_count = wr_count + 9'd1;
    return 1'b1;
  endfunction

  function automatic void open_block(input logic [7:0] code);
    if (code == 8'd1) begin
      in_blk    = 1'b0;
      zero_due  = 1'b1;
      blk_left  = '0;
      full_code = 1'b0;
    end else begin
      in_blk    = 1'b1;
      blk_left  = code - 8'd1;
      full_code = (code == 8'hFF);
    end
  endfunction

  // Advances the model by one accepted request and queues the result it must produce.
  function automatic void decode_request(input req_t r);
    result_t e;
    e.status   = ST_CONSUMED;
    e.data_out = '0;
    e.pkt_len  = '0;
    if (r.op == OP_READ) begin
      if (done) begin
        e.data_out = (r.read_index < wr_count) ? store_mem[r.read_index] : 8'd0;
        e.pkt_len  = wr_count;
      end
    end else begin
      if (done) clear_frame();
      if (r.data_byte == 8'd0) begin
        if (in_blk) begin
          e.status = ST_DECODE_ERR;
        end else if (wr_count < 9'd2 || {hold0, hold1} != crc_acc) begin
          e.status = ST_CRC_ERR;
        end else begin
          e.status = ST_READY;
          wr_count = wr_count - 9'd2;
        end
      end else if (zero_due) begin
        if (!store_decoded(8'd0)) begin
          e.status = ST_OVERFLOW;
        end else begin
          zero_due = 1'b0;
          open_block(r.data_byte);
        end
      end else if (!in_blk) begin
        open_block(r.data_byte);
      end else if (!store_decoded(r.data_byte)) begin
        e.status = ST_OVERFLOW;
      end else begin
        if (blk_left > 8'd0) blk_left = blk_left - 8'd1;
        if (blk_left == 8'd0) begin
          in_blk = 1'b0;
          if (!full_code) zero_due = 1'b1;
        end
      end
      if (e.status != ST_CONSUMED) begin
        done      = 1'b1;
        e.pkt_len = wr_count;
      end
    end
    expected_q.push_back(e);
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void push_feed(input logic [7:0] b);
    req_t r;
    r.op         = OP_FEED;
    r.data_byte  = b;
    r.read_index = 8'($urandom);
    pending_q.push_back(r);
    queued_items++;
  endfunction

  function automatic void push_read(input logic [7:0] idx);
    req_t r;
    r.op         = OP_READ;
    r.data_byte  = 8'($urandom);
    r.read_index = idx;
    pending_q.push_back(r);
    queued_items++;
  endfunction

  function automatic byte_q random_body(input int len, input int zero_pct);
    byte_q q;
    repeat (len) q.push_back(($urandom_range(99) < zero_pct) ? 8'd0 : 8'($urandom_range(255, 1)));
    return q;
  endfunction

  // Appends the CRC big-endian, COBS-encodes the result and queues it with its delimiter.
  function automatic void queue_frame(input byte_q body, input frame_kind_t kind);
    byte_q       raw;
    byte_q       enc;
    logic [15:0] c;
    int          i;
    int          n;
    int          stop;
    c = cfg_crc_init;
    foreach (body[k]) c = crc16_next(c, body[k]);
    if (kind == FRAME_BAD_CRC) c = c ^ (16'd1 << $urandom_range(15));
    raw = body;
    raw.push_back(c[15:8]);
    raw.push_back(c[7:0]);
    i = 0;
    forever begin
      n = 0;
      while (i + n < raw.size() && raw[i + n] != 8'd0 && n < 254) n++;
      enc.push_back(8'(n + 1));
      for (int k = 0; k < n; k++) enc.push_back(raw[i + k]);
      i += n;
      if (i >= raw.size()) break;
      if (n < 254) i++;
    end
    stop = (kind == FRAME_CUT) ? $urandom_range(enc.size() - 1) : enc.size();
    for (int k = 0; k < stop; k++) push_feed(enc[k]);
    push_feed(8'd0);
  endfunction

  task automatic wait_idle();
    while (accepted_total != queued_items || expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_LENGTH) cfg_max_len = value[8:0];
    else cfg_crc_init = value;
  endtask

  task automatic run_phase(input int n_items);
    int lim;
    int first;
    int pick;
    int len;
    lim   = length_cap();
    first = queued_items;
    while (queued_items - first < n_items) begin
      pick = $urandom_range(99);
      if (pick < 58) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(lim - 2)
                                        : $urandom_range((lim - 2 < 20) ? lim - 2 : 20);
        queue_frame(random_body(len, ($urandom_range(3) == 0) ? 0 : 20), FRAME_GOOD);
      end else if (pick < 66) begin
        queue_frame(random_body($urandom_range(8), 20), FRAME_BAD_CRC);
      end else if (pick < 72) begin
        if (lim <= 64 || $urandom_range(15) == 0)
          queue_frame(random_body(lim - 1 + $urandom_range(2), 20), FRAME_GOOD);
      end else if (pick < 80) begin
        repeat ($urandom_range(4, 1))
          push_read(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(24)));
      end else if (pick < 90) begin
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(4) == 0) push_read(8'($urandom));
          else push_feed(($urandom_range(2) == 0) ? 8'd0 : 8'($urandom));
        end
      end else begin
        queue_frame(random_body($urandom_range((lim - 2 < 12) ? lim - 2 : 12), 20), FRAME_CUT);
      end
      if ($urandom_range(2) == 0) push_read(8'($urandom_range(24)));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_request(cur_req);
        accepted_total <= accepted_total + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          cur_req = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_req.read_index, cur_req.data_byte};
          s_axis_tuser  <= cur_req.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          note_error($sformatf("unexpected result: status %0d data %h", m_axis_tuser,
                               m_axis_tdata));
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tuser !== want.status || m_axis_tdata[7:0] !== want.data_out ||
              m_axis_tdata[16:8] !== want.pkt_len || m_axis_tdata[23:17] !== 7'd0)
            note_error($sformatf("status %0d data %h length %0d, expected %0d %h %0d",
                                 m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[16:8],
                                 want.status, want.data_out, want.pkt_len));
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // One long receiver stall while requests keep coming, so the input side backs up.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && accepted_total >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    byte_q body;
    clear_frame();
    sender_idle_pct = 32;
    sink_idle_pct   = 58;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    push_read(8'd0);
    push_feed(8'd0);
    push_read(8'd255);
    body = '{8'h00, 8'h11, 8'hFF, 8'h00};
    queue_frame(body, FRAME_GOOD);
    push_read(8'd0);
    push_read(8'd4);
    body = '{8'h42};
    queue_frame(body, FRAME_BAD_CRC);
    push_feed(8'hFF);
    push_feed(8'h01);
    push_feed(8'h00);
    push_feed(8'h02);
    push_feed(8'h7E);
    push_feed(8'h00);

    write_reg(CFG_MAX_LENGTH, 16'd2);
    write_reg(CFG_CRC_INIT, 16'h0000);
    body = {};
    queue_frame(body, FRAME_GOOD);
    push_read(8'd0);
    body = '{8'h01};
    queue_frame(body, FRAME_GOOD);

    write_reg(CFG_MAX_LENGTH, 16'd256);
    write_reg(CFG_CRC_INIT, 16'hFFFF);
    run_phase(100);
    write_reg(CFG_MAX_LENGTH, 16'd17);
    write_reg(CFG_CRC_INIT, 16'($urandom));
    run_phase(100);

    sender_idle_pct = 58;
    sink_idle_pct   = 32;
    write_reg(CFG_MAX_LENGTH, 16'd511);
    write_reg(CFG_CRC_INIT, 16'h1D0F);
    run_phase(95);
    write_reg(CFG_MAX_LENGTH, 16'd3);
    run_phase(95);

    sender_idle_pct = 0;
    sink_idle_pct   = 0;
    write_reg(CFG_MAX_LENGTH, 16'(2 + $urandom_range(60)));
    write_reg(CFG_CRC_INIT, 16'h0000);
    run_phase(100);
    write_reg(CFG_MAX_LENGTH, 16'd256);
    write_reg(CFG_CRC_INIT, 16'hFFFF);
    queue_frame(random_body(254, 0), FRAME_GOOD);
    push_read(8'd253);
    run_phase(95);

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/cobsdec_pkg.sv
rtl/cobsdec_ram.sv
rtl/cobs_frame_decoder_crc16_top.sv
verif/tb_top.sv
